// ----- sv/mm2_pkg.sv -----
package mm2_pkg;

    localparam logic [31:0] SEED_RESET  = 32'hBAADFEED;
    localparam logic [31:0] MIX_MUL     = 32'h5BD1E995;
    localparam logic [31:0] MAX_LENGTH  = 32'd65535;

    // bucket mixing constants
    localparam logic [31:0] BKT_MUL_T   = 32'd4097;
    localparam logic [31:0] BKT_ADD_T   = 32'd2127912214;
    localparam logic [31:0] BKT_XOR_V   = 32'hC761C23C;
    localparam logic [31:0] BKT_MUL_M   = 32'd33;
    localparam logic [31:0] BKT_ADD_V   = 32'd374761393;
    localparam logic [31:0] BKT_SUB_A   = 32'd369570787;
    localparam logic [31:0] BKT_MUL_A   = 32'd9;
    localparam logic [31:0] BKT_SUB_K   = 32'd42973499;
    localparam logic [31:0] BKT_XOR_B   = 32'hB55A4F09;
    localparam logic [31:0] BKT_ADD_0   = 32'd29;
    localparam logic [31:0] BKT_SUB_0   = 32'd59;
    localparam logic [31:0] BKT_SUB_2   = 32'd13283;
    localparam logic [31:0] BKT_ADD_2   = 32'd18117;
    localparam logic [31:0] BKT_XOR_W   = 32'h00004F09;
    localparam logic [7:0]  BKT_XOR_OUT = 8'h09;

    typedef struct packed {
        logic        en;
        logic [31:0] op_a;
        logic [31:0] op_b;
    } mul_req_t;

endpackage

// ----- sv/murmur2_string_hash_bucket_core.sv -----
// A byte that neither completes a word nor ends the string is taken without leaving idle;
// a byte completing a 4-byte word runs states S_W1 to S_W4 before the next byte is taken.
// After a last byte the hash runs states S_F0 to S_F3 (S_F1 only with leftover bytes)
// and S_B0 to S_B6; the result is loaded once the output slot is free.
// Reset (rst_n, async low) loads the seed 0xBAADFEED and clears the running hash, pending
// bytes and output valid.
module murmur2_string_hash_bucket_core
    import mm2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        hash_seed_wr_en,
    input  logic [31:0] hash_seed_wr_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  byte_value,
    input  logic [15:0] string_length,
    input  logic        first_item,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value,
    output logic [7:0]  bucket
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_W1   = 4'd1;
    localparam logic [3:0] S_W2   = 4'd2;
    localparam logic [3:0] S_W3   = 4'd3;
    localparam logic [3:0] S_W4   = 4'd4;
    localparam logic [3:0] S_F0   = 4'd5;
    localparam logic [3:0] S_F1   = 4'd6;
    localparam logic [3:0] S_F2   = 4'd7;
    localparam logic [3:0] S_F3   = 4'd8;
    localparam logic [3:0] S_B0   = 4'd9;
    localparam logic [3:0] S_B1   = 4'd10;
    localparam logic [3:0] S_B2   = 4'd11;
    localparam logic [3:0] S_B3   = 4'd12;
    localparam logic [3:0] S_B4   = 4'd13;
    localparam logic [3:0] S_B5   = 4'd14;
    localparam logic [3:0] S_B6   = 4'd15;

    // control state
    logic [3:0]  state_reg, state_next;
    logic [31:0] seed_reg;
    logic [31:0] acc_reg, acc_next;
    logic [23:0] pend_reg, pend_next;
    logic [1:0]  pos_reg, pos_next;
    logic        out_valid_reg, out_valid_next;

    // datapath scratch
    logic [31:0] k_reg, k_next;
    logic [31:0] s_reg, s_next;
    logic [31:0] m_reg, m_next;
    logic [31:0] v5_reg, v5_next;
    logic [7:0]  x0_reg, x0_next;
    logic        last_reg, last_next;
    logic [31:0] hash_reg, hash_next;
    logic [7:0]  bucket_reg, bucket_next;

    mul_req_t    mul_req;
    logic [31:0] prod;

    logic        accept;
    logic        out_free;
    logic        skip_byte;
    logic [31:0] len_ext;
    logic [31:0] len_sat;
    logic [31:0] acc0;
    logic [23:0] pend0;
    logic [1:0]  pos0;
    logic [31:0] t_mix;
    logic [31:0] a_hi;
    logic [31:0] b_mix;
    logic [31:0] b_hi;
    logic [31:0] w_mix;
    logic [31:0] x_tmp;

    mm2_mult u_mult
    (
        .clk  (clk),
        .req  (mul_req),
        .prod (prod)
    );

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    assign len_ext   = {16'h0000, string_length};
    assign len_sat   = (len_ext > MAX_LENGTH) ? MAX_LENGTH : len_ext;
    assign acc0      = first_item ? (seed_reg ^ len_sat) : acc_reg;
    assign pend0     = first_item ? 24'h000000 : pend_reg;
    assign pos0      = first_item ? 2'd0 : pos_reg;
    assign skip_byte = first_item && last_item && (string_length == 16'h0000);

    always_comb
    begin
        state_next     = state_reg;
        acc_next       = acc_reg;
        pend_next      = pend_reg;
        pos_next       = pos_reg;
        out_valid_next = out_valid_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        m_next         = m_reg;
        v5_next        = v5_reg;
        x0_next        = x0_reg;
        last_next      = last_reg;
        hash_next      = hash_reg;
        bucket_next    = bucket_reg;
        mul_req        = '0;
        t_mix          = s_reg ^ (s_reg >> 19) ^ BKT_XOR_V;
        a_hi           = {16'h0000, s_reg[31:16]};
        b_mix          = a_hi ^ s_reg ^ BKT_XOR_B;
        b_hi           = {16'h0000, b_mix[31:16]};
        w_mix          = a_hi ^ (prod + BKT_ADD_2) ^ BKT_XOR_W ^ b_hi;
        x_tmp          = prod - BKT_SUB_0;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    acc_next  = acc0;
                    last_next = last_item;
                    pend_next = pend0;
                    pos_next  = pos0;
                    if (!skip_byte && (pos0 == 2'd3))
                    begin
                        k_next     = {byte_value, pend0};
                        state_next = S_W1;
                    end
                    else
                    begin
                        if (!skip_byte)
                        begin
                            case (pos0)
                                2'd0:    pend_next = {pend0[23:8], byte_value};
                                2'd1:    pend_next = {pend0[23:16], byte_value, pend0[7:0]};
                                default: pend_next = {byte_value, pend0[15:0]};
                            endcase
                            pos_next = pos0 + 2'd1;
                        end
                        if (last_item)
                        begin
                            state_next = S_F0;
                        end
                    end
                end
            end
            S_W1:
            begin
                mul_req    = '{en: 1'b1, op_a: k_reg, op_b: MIX_MUL};
                state_next = S_W2;
            end
            S_W2:
            begin
                mul_req    = '{en: 1'b1, op_a: prod ^ (prod >> 24), op_b: MIX_MUL};
                state_next = S_W3;
            end
            S_W3:
            begin
                k_next     = prod;
                mul_req    = '{en: 1'b1, op_a: acc_reg, op_b: MIX_MUL};
                state_next = S_W4;
            end
            S_W4:
            begin
                acc_next   = prod ^ k_reg;
                pend_next  = 24'h000000;
                pos_next   = 2'd0;
                state_next = last_reg ? S_F0 : S_IDLE;
            end
            S_F0:
            begin
                // fold leftover bytes, if any
                if (pos_reg != 2'd0)
                begin
                    mul_req    = '{en: 1'b1, op_a: acc_reg ^ {8'h00, pend_reg}, op_b: MIX_MUL};
                    state_next = S_F1;
                end
                else
                begin
                    s_next     = acc_reg;
                    state_next = S_F2;
                end
            end
            S_F1:
            begin
                s_next     = prod;
                state_next = S_F2;
            end
            S_F2:
            begin
                mul_req    = '{en: 1'b1, op_a: s_reg ^ (s_reg >> 13), op_b: MIX_MUL};
                state_next = S_F3;
            end
            S_F3:
            begin
                // hold the finished hash in the accumulator until the result is loaded
                acc_next   = prod ^ (prod >> 15);
                pend_next  = 24'h000000;
                pos_next   = 2'd0;
                state_next = S_B0;
            end
            S_B0:
            begin
                mul_req    = '{en: 1'b1, op_a: acc_reg, op_b: BKT_MUL_T};
                state_next = S_B1;
            end
            S_B1:
            begin
                s_next     = prod + BKT_ADD_T;
                state_next = S_B2;
            end
            S_B2:
            begin
                mul_req    = '{en: 1'b1, op_a: t_mix, op_b: BKT_MUL_M};
                state_next = S_B3;
            end
            S_B3:
            begin
                m_next     = prod;
                v5_next    = (prod + BKT_ADD_V) << 9;
                state_next = S_B4;
            end
            S_B4:
            begin
                mul_req    = '{en: 1'b1, op_a: v5_reg ^ (m_reg - BKT_SUB_A), op_b: BKT_MUL_A};
                state_next = S_B5;
            end
            S_B5:
            begin
                s_next     = prod - BKT_SUB_K;
                mul_req    = '{en: 1'b1, op_a: v5_reg ^ (m_reg + BKT_ADD_0), op_b: BKT_MUL_A};
                last_next  = 1'b0;
                state_next = S_B6;
            end
            S_B6:
            begin
                // last_reg marks the second pass: issue first, then finish when the slot frees
                if (!last_reg)
                begin
                    x0_next   = s_reg[23:16] ^ x_tmp[7:0];
                    mul_req   = '{en: 1'b1, op_a: v5_reg ^ (m_reg - BKT_SUB_2), op_b: BKT_MUL_A};
                    last_next = 1'b1;
                end
                else if (out_free)
                begin
                    hash_next      = acc_reg;
                    bucket_next    = x0_reg ^ BKT_XOR_OUT ^ b_hi[7:0] ^ w_mix[15:8];
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seed_reg      <= SEED_RESET;
            acc_reg       <= 32'h00000000;
            pend_reg      <= 24'h000000;
            pos_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_reg       <= acc_next;
            pend_reg      <= pend_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
            if (hash_seed_wr_en)
            begin
                seed_reg <= hash_seed_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg      <= k_next;
        s_reg      <= s_next;
        m_reg      <= m_next;
        v5_reg     <= v5_next;
        x0_reg     <= x0_next;
        last_reg   <= last_next;
        hash_reg   <= hash_next;
        bucket_reg <= bucket_next;
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = hash_reg;
    assign bucket     = bucket_reg;

    // an empty partial word carries no pending bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        (pos_reg == 2'd0) |-> (pend_reg == 24'h000000))
        else $error("pending bytes set with empty partial word");

    // a finished result leaves the running hash equal to it and the word cleared
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_B6 && last_reg && out_free) |=>
        (out_valid && hash_value == acc_reg && pos_reg == 2'd0))
        else $error("result loaded without matching accumulator");

    // a result never overwrites one still waiting
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_B6 && last_reg && !out_free) |=> (state_reg == S_B6))
        else $error("bucket stage left while output slot busy");

    // a last item always runs the finish sequence before new input
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last_item) |=> !in_ready)
        else $error("input taken before finishing a string");

endmodule

// ----- sv/mm2_mult.sv -----
module mm2_mult
    import mm2_pkg::*;
(
    input  logic        clk,
    input  mul_req_t    req,
    output logic [31:0] prod
);

    logic [31:0] prod_reg;
    logic [31:0] prod_next;

    // low half of the product is all the hash ever needs
    assign prod_next = req.op_a * req.op_b;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= prod_next;
        end
    end

    assign prod = prod_reg;

endmodule
